>>> rtl/qcps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcps_pkg
// shared types and constants for the connection-id steering core
// ----------------------------------------------------------------------------
package qcps_pkg;

    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_PORT = 2'd1;
    localparam logic [1:0] CMD_CONN = 2'd2;

    localparam logic [15:0] ETYPE_V4  = 16'h0800;
    localparam logic [15:0] ETYPE_V6  = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam logic [1:0] VERDICT_NONE     = 2'd0;
    localparam logic [1:0] VERDICT_CONN     = 2'd1;
    localparam logic [1:0] VERDICT_FALLBACK = 2'd2;

    localparam logic [2:0] RSN_OK       = 3'd0;
    localparam logic [2:0] RSN_NOT_IP   = 3'd1;
    localparam logic [2:0] RSN_NOT_UDP  = 3'd2;
    localparam logic [2:0] RSN_UNLISTED = 3'd3;
    localparam logic [2:0] RSN_SHORT    = 3'd4;
    localparam logic [2:0] RSN_ID_SHORT = 3'd5;
    localparam logic [2:0] RSN_NO_ENTRY = 3'd6;

    localparam int JOB_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_DONE,
        JOB_LOOKUP
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [5:0]  slot;
        logic        valid;
        logic [63:0] key;
        logic [31:0] socket;
        logic [15:0] port;
        logic        family;
        logic [2:0]  reason;
    } job_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] socket;
        logic [2:0]  reason;
        logic [15:0] port;
        logic [63:0] key;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EMIT
    } back_state_t;

endpackage
`default_nettype wire

>>> rtl/qcps_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcps_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module qcps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/qcps_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcps_fifo
// small register queue, depth a power of two
// ----------------------------------------------------------------------------
module qcps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] dout,
    output logic                  empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store [DEPTH];
    logic [AW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = store[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_reg] <= din;
        end
    end
endmodule
`default_nettype wire

>>> rtl/qcps_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcps_front
// byte parser, listed-port table and job issue at frame end and on connection writes
// ----------------------------------------------------------------------------
module qcps_front #(
    parameter int CID_BYTES  = 8,
    parameter int PORT_SLOTS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [1:0]    command,
    input  wire logic [7:0]    data_byte,
    input  wire logic          frame_end,
    input  wire logic [5:0]    slot_index,
    input  wire logic          entry_valid,
    input  wire logic [15:0]   entry_port,
    input  wire logic [63:0]   entry_key,
    input  wire logic [31:0]   entry_socket,
    output logic               job_push,
    output qcps_pkg::job_t     job
);
    import qcps_pkg::*;

    localparam int PA = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;

    logic [7:0]  pos_reg, pos_next;
    logic [15:0] ft_reg, ft_next;
    logic [6:0]  l4_reg, l4_next;
    logic        fam_reg, fam_next;
    logic [15:0] port_reg, port_next;
    logic [7:0]  hf_reg, hf_next;
    logic [7:0]  idl_reg, idl_next;
    logic [63:0] acc_reg, acc_next;
    logic        udp_reg, udp_next;

    logic             pv_reg [PORT_SLOTS];
    logic [15:0]      pnum_reg [PORT_SLOTS];
    logic             pwe;
    logic [PA-1:0]    pidx;

    logic [7:0]  l4b, ids, d, len, minlen;
    logic        ipf, listed;

    assign pidx = PA'(slot_index);

    always_comb
    begin
        pos_next  = pos_reg;
        ft_next   = ft_reg;
        l4_next   = l4_reg;
        fam_next  = fam_reg;
        port_next = port_reg;
        hf_next   = hf_reg;
        idl_next  = idl_reg;
        acc_next  = acc_reg;
        udp_next  = udp_reg;
        pwe       = 1'b0;
        job_push  = 1'b0;
        job       = '0;
        listed    = 1'b0;
        ipf       = (ft_reg == ETYPE_V4) || (ft_reg == ETYPE_V6);
        l4b       = {1'b0, l4_reg};
        ids       = l4b + (hf_reg[7] ? 8'd14 : 8'd9);
        d         = pos_reg - ids;
        len       = 8'd0;
        minlen    = 8'd0;

        if (accept)
        begin
            case (command)
                CMD_BYTE:
                begin
                    if (pos_reg == 8'd12)
                    begin
                        ft_next = {data_byte, 8'h00};
                    end
                    if (pos_reg == 8'd13)
                    begin
                        ft_next = {ft_reg[15:8], data_byte};
                    end
                    if (pos_reg == 8'd14)
                    begin
                        if (ft_reg == ETYPE_V4)
                        begin
                            l4_next  = 7'd14 + {1'b0, data_byte[3:0], 2'b00};
                            fam_next = 1'b0;
                        end
                        else
                        begin
                            l4_next  = 7'd54;
                            fam_next = 1'b1;
                        end
                    end
                    if (pos_reg >= 8'd14 && ipf && data_byte == PROTO_UDP &&
                        pos_reg == ((ft_reg == ETYPE_V4) ? 8'd23 : 8'd20))
                    begin
                        udp_next = 1'b1;
                    end
                    if (pos_reg > 8'd14 && ipf)
                    begin
                        if (pos_reg == l4b + 8'd2)
                        begin
                            port_next = {data_byte, 8'h00};
                        end
                        if (pos_reg == l4b + 8'd3)
                        begin
                            port_next = {port_reg[15:8], data_byte};
                        end
                        if (pos_reg == l4b + 8'd8)
                        begin
                            hf_next = data_byte;
                        end
                        if (pos_reg == l4b + 8'd13)
                        begin
                            idl_next = data_byte;
                        end
                        if (pos_reg >= l4b + 8'd9 && pos_reg >= ids)
                        begin
                            for (int k = 0; k < CID_BYTES; k++)
                            begin
                                if (d == 8'(k))
                                begin
                                    acc_next[8*k +: 8] = acc_reg[8*k +: 8] | data_byte;
                                end
                            end
                        end
                    end
                    if (pos_reg != 8'd255)
                    begin
                        pos_next = pos_reg + 8'd1;
                    end

                    if (frame_end)
                    begin
                        // verdict checks on the post-byte state
                        len      = pos_next;
                        l4b      = {1'b0, l4_next};
                        ids      = l4b + (hf_next[7] ? 8'd14 : 8'd9);
                        minlen   = (ft_next == ETYPE_V4) ? 8'd24 : 8'd21;
                        job_push = 1'b1;
                        job.kind = JOB_DONE;
                        job.family = fam_next;
                        if (len < 8'd14)
                        begin
                            job.reason = RSN_SHORT;
                        end
                        else if (!(ft_next == ETYPE_V4 || ft_next == ETYPE_V6))
                        begin
                            job.reason = RSN_NOT_IP;
                        end
                        else if (len < minlen)
                        begin
                            job.reason = RSN_SHORT;
                        end
                        else if (!udp_next)
                        begin
                            job.reason = RSN_NOT_UDP;
                        end
                        else if (len < l4b + 8'd4)
                        begin
                            job.reason = RSN_SHORT;
                        end
                        else
                        begin
                            job.port = port_next;
                            // lowest listed slot is enough, any hit lists the port
                            for (int i = 0; i < PORT_SLOTS; i++)
                            begin
                                if (pv_reg[i] && pnum_reg[i] == port_next)
                                begin
                                    listed = 1'b1;
                                end
                            end
                            if (!listed)
                            begin
                                job.reason = RSN_UNLISTED;
                            end
                            else if (len < l4b + 8'd9)
                            begin
                                job.reason = RSN_SHORT;
                            end
                            else if (hf_next[7] && len < l4b + 8'd14)
                            begin
                                job.reason = RSN_SHORT;
                            end
                            else if (hf_next[7] && idl_next < 8'(CID_BYTES))
                            begin
                                job.reason = RSN_ID_SHORT;
                            end
                            else if (len < ids + 8'(CID_BYTES))
                            begin
                                job.reason = RSN_SHORT;
                            end
                            else
                            begin
                                job.kind = JOB_LOOKUP;
                                job.key  = acc_next;
                            end
                        end
                        pos_next  = '0;
                        ft_next   = '0;
                        l4_next   = '0;
                        fam_next  = 1'b0;
                        port_next = '0;
                        hf_next   = '0;
                        idl_next  = '0;
                        acc_next  = '0;
                        udp_next  = 1'b0;
                    end
                end
                CMD_PORT:
                begin
                    pwe = (32'(slot_index) < PORT_SLOTS);
                end
                CMD_CONN:
                begin
                    job_push   = 1'b1;
                    job.kind   = JOB_WRITE;
                    job.slot   = slot_index;
                    job.valid  = entry_valid;
                    job.key    = entry_key;
                    job.socket = entry_socket;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            ft_reg   <= '0;
            l4_reg   <= '0;
            fam_reg  <= 1'b0;
            port_reg <= '0;
            hf_reg   <= '0;
            idl_reg  <= '0;
            acc_reg  <= '0;
            udp_reg  <= 1'b0;
            for (int i = 0; i < PORT_SLOTS; i++)
            begin
                pv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            pos_reg  <= pos_next;
            ft_reg   <= ft_next;
            l4_reg   <= l4_next;
            fam_reg  <= fam_next;
            port_reg <= port_next;
            hf_reg   <= hf_next;
            idl_reg  <= idl_next;
            acc_reg  <= acc_next;
            udp_reg  <= udp_next;
            if (pwe)
            begin
                pv_reg[pidx] <= entry_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pwe)
        begin
            pnum_reg[pidx] <= entry_port;
        end
    end
endmodule
`default_nettype wire

>>> rtl/qcps_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcps_back
// connection table writes, lowest-slot exact-match scan and result issue
// ----------------------------------------------------------------------------
module qcps_back #(
    parameter int CONN_SLOTS = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             job_valid,
    input  qcps_pkg::job_t        job,
    output logic                  job_pop,
    input  wire logic             res_full,
    output logic                  res_push,
    output qcps_pkg::result_t     res
);
    import qcps_pkg::*;

    localparam int CA = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;
    localparam int CW = $clog2(CONN_SLOTS + 1);

    back_state_t  state_reg, state_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic          pend_reg, pend_next;
    logic [CA-1:0] pidx_reg, pidx_next;
    logic          hit1_reg, hit1_next, hit2_reg, hit2_next;
    logic [31:0]   sock1_reg, sock1_next, sock2_reg, sock2_next;
    logic [63:0]   key_reg, key_next;
    logic [63:0]   fb_reg, fb_next;
    logic [15:0]   port_reg, port_next;
    logic          cv_reg [CONN_SLOTS];

    logic          ram_we, ram_re, vwe;
    logic [CA-1:0] waddr;
    logic [95:0]   rdata;

    assign waddr = CA'(job.slot);

    qcps_ram #(.WIDTH(96), .DEPTH(CONN_SLOTS)) u_conn_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata ({job.key, job.socket}),
        .re    (ram_re),
        .raddr (iss_reg[CA-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        iss_next   = iss_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        hit1_next  = hit1_reg;
        hit2_next  = hit2_reg;
        sock1_next = sock1_reg;
        sock2_next = sock2_reg;
        key_next   = key_reg;
        fb_next    = fb_reg;
        port_next  = port_reg;
        job_pop    = 1'b0;
        res_push   = 1'b0;
        res        = '0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        vwe        = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    case (job.kind)
                        JOB_WRITE:
                        begin
                            job_pop = 1'b1;
                            if (32'(job.slot) < CONN_SLOTS)
                            begin
                                ram_we = 1'b1;
                                vwe    = 1'b1;
                            end
                        end
                        JOB_LOOKUP:
                        begin
                            job_pop    = 1'b1;
                            key_next   = job.key;
                            fb_next    = {47'd0, job.port, job.family};
                            port_next  = job.port;
                            hit1_next  = 1'b0;
                            hit2_next  = 1'b0;
                            iss_next   = '0;
                            pend_next  = 1'b0;
                            state_next = BK_SCAN;
                        end
                        default:
                        begin
                            if (!res_full)
                            begin
                                job_pop     = 1'b1;
                                res_push    = 1'b1;
                                res.verdict = VERDICT_NONE;
                                res.reason  = job.reason;
                                res.port    = job.port;
                                res.key     = job.key;
                            end
                        end
                    endcase
                end
            end
            BK_SCAN:
            begin
                // each read is compared in the cycle after it is issued
                pend_next = (iss_reg < CW'(CONN_SLOTS));
                if (pend_next)
                begin
                    ram_re    = 1'b1;
                    pidx_next = iss_reg[CA-1:0];
                    iss_next  = iss_reg + 1'b1;
                end
                if (pend_reg && cv_reg[pidx_reg])
                begin
                    if (!hit1_reg && rdata[95:32] == key_reg)
                    begin
                        hit1_next  = 1'b1;
                        sock1_next = rdata[31:0];
                    end
                    if (!hit2_reg && rdata[95:32] == fb_reg)
                    begin
                        hit2_next  = 1'b1;
                        sock2_next = rdata[31:0];
                    end
                end
                if (!pend_next && !pend_reg)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    res.port   = port_reg;
                    res.key    = key_reg;
                    if (hit1_reg)
                    begin
                        res.verdict = VERDICT_CONN;
                        res.socket  = sock1_reg;
                        res.reason  = RSN_OK;
                    end
                    else if (hit2_reg)
                    begin
                        res.verdict = VERDICT_FALLBACK;
                        res.socket  = sock2_reg;
                        res.reason  = RSN_OK;
                    end
                    else
                    begin
                        res.verdict = VERDICT_NONE;
                        res.reason  = RSN_NO_ENTRY;
                    end
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            iss_reg   <= '0;
            pend_reg  <= 1'b0;
            hit1_reg  <= 1'b0;
            hit2_reg  <= 1'b0;
            for (int i = 0; i < CONN_SLOTS; i++)
            begin
                cv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            iss_reg   <= iss_next;
            pend_reg  <= pend_next;
            hit1_reg  <= hit1_next;
            hit2_reg  <= hit2_next;
            if (vwe)
            begin
                cv_reg[waddr] <= job.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg  <= pidx_next;
        sock1_reg <= sock1_next;
        sock2_reg <= sock2_next;
        key_reg   <= key_next;
        fb_reg    <= fb_next;
        port_reg  <= port_next;
    end
endmodule
`default_nettype wire

>>> rtl/quic_cid_packet_steering_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quic_cid_packet_steering_core
// steers udp/quic frames to sockets by destination connection id
// ----------------------------------------------------------------------------
// Frame bytes (command 0) are taken one per cycle while full is low and parsed
// in the front section, which also owns the listed-port table (command 1,
// applied at once). At the last byte of a frame the front pushes one job into
// a four-word job queue; connection table writes (command 2) travel through
// the same queue so they stay ordered against lookups. Frames that fail
// parsing leave the back section as soon as it is idle and the result queue
// has room. A frame that needs a table match is scanned over the connection
// ram, one slot per cycle, from slot 0 up so the lowest matching slot wins
// for both the id key and the port*2+family fallback key, paced by the single
// ram read port. Bytes keep flowing while the scan runs; full rises only when
// the job queue holds four pending jobs. Results wait in a two-word output
// queue; the oldest is shown while empty is low and leaves on pop.
module quic_cid_packet_steering_core #(
    parameter int CID_BYTES  = 8,
    parameter int PORT_SLOTS = 16,
    parameter int CONN_SLOTS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_end,
    input  wire logic [5:0]  slot_index,
    input  wire logic        entry_valid,
    input  wire logic [15:0] entry_port,
    input  wire logic [63:0] entry_key,
    input  wire logic [31:0] entry_socket,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       verdict,
    output logic [31:0]      socket_id,
    output logic [2:0]       reason,
    output logic [15:0]      dest_port,
    output logic [63:0]      cid_key
);
    import qcps_pkg::*;

    // front to queue
    logic    accept;
    logic    fj_push;
    job_t    fj;

    // queue to back
    logic    jq_empty, jq_pop;
    job_t    jq_dout;

    // back to result queue
    logic    rq_full, rq_push;
    result_t rq_din, rq_dout;

    assign accept = push && !full;

    qcps_front #(.CID_BYTES(CID_BYTES), .PORT_SLOTS(PORT_SLOTS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .command      (command),
        .data_byte    (data_byte),
        .frame_end    (frame_end),
        .slot_index   (slot_index),
        .entry_valid  (entry_valid),
        .entry_port   (entry_port),
        .entry_key    (entry_key),
        .entry_socket (entry_socket),
        .job_push     (fj_push),
        .job          (fj)
    );

    // job queue decouples byte parsing from the table scan
    qcps_fifo #(.WIDTH($bits(job_t)), .DEPTH(JOB_DEPTH)) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fj_push),
        .din   (fj),
        .full  (full),
        .pop   (jq_pop),
        .dout  (jq_dout),
        .empty (jq_empty)
    );

    qcps_back #(.CONN_SLOTS(CONN_SLOTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!jq_empty),
        .job       (jq_dout),
        .job_pop   (jq_pop),
        .res_full  (rq_full),
        .res_push  (rq_push),
        .res       (rq_din)
    );

    // result queue parts the scan from the consumer
    qcps_fifo #(.WIDTH($bits(result_t)), .DEPTH(RES_DEPTH)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .din   (rq_din),
        .full  (rq_full),
        .pop   (pop),
        .dout  (rq_dout),
        .empty (empty)
    );

    assign verdict   = rq_dout.verdict;
    assign socket_id = rq_dout.socket;
    assign reason    = rq_dout.reason;
    assign dest_port = rq_dout.port;
    assign cid_key   = rq_dout.key;
endmodule
`default_nettype wire

>>> test/quic_cid_packet_steering_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quic_cid_packet_steering_core_tb
// self-checking bench for the connection-id steering core
// ----------------------------------------------------------------------------
// Frames are built byte by byte with chosen ethertype, ihl, protocol, port,
// header form, id length and id, sometimes cut short or padded past the
// byte counter limit. Port and connection table writes are mixed in. An
// in-bench steering model predicts one verdict word per frame; a separate
// process pops and compares every field against the oldest prediction.
module quic_cid_packet_steering_core_tb;
    import qcps_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;   // unused command code, ignored
    localparam int ID_LEN = 8;
    localparam int N_PORT = 16;
    localparam int N_CONN = 64;
    localparam int IDLE_LIMIT = 3000;         // cycles with no handshake at all

    typedef bit [7:0] frame_q_t[$];

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  command = CMD_BYTE;
    logic [7:0]  data_byte = '0;
    logic        frame_end = 1'b0;
    logic [5:0]  slot_index = '0;
    logic        entry_valid = 1'b0;
    logic [15:0] entry_port = '0;
    logic [63:0] entry_key = '0;
    logic [31:0] entry_socket = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  verdict;
    logic [31:0] socket_id;
    logic [2:0]  reason;
    logic [15:0] dest_port;
    logic [63:0] cid_key;

    quic_cid_packet_steering_core i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .command(command), .data_byte(data_byte), .frame_end(frame_end),
        .slot_index(slot_index), .entry_valid(entry_valid),
        .entry_port(entry_port), .entry_key(entry_key),
        .entry_socket(entry_socket), .empty(empty), .pop(pop),
        .verdict(verdict), .socket_id(socket_id), .reason(reason),
        .dest_port(dest_port), .cid_key(cid_key)
    );

    always #5 clk = ~clk;

    // steering model state
    bit          port_on[N_PORT];
    bit [15:0]   port_num[N_PORT];
    bit          conn_on[N_CONN];
    bit [63:0]   conn_key[N_CONN];
    bit [31:0]   conn_sock[N_CONN];
    int          f_pos, f_type, f_l4, f_family, f_port, f_form, f_idlen;
    bit          f_udp;
    bit [63:0]   f_id;

    result_t     steer_expected[$];
    bit [63:0]   known_ids[$];
    bit [15:0]   listed_ports[$];

    int          failures = 0;
    int          words_sent = 0;
    int          frames_sent = 0;
    int          words_popped = 0;
    int          seen_by_verdict[3];
    int          hold_len = 0;        // receiver hold-off request
    bit          no_gaps = 1'b0;      // sender runs back to back when set
    int          idle_cycles = 0;

    function automatic void clear_frame_state();
        f_pos = 0; f_type = 0; f_l4 = 0; f_family = 0; f_port = 0;
        f_form = 0; f_idlen = 0; f_udp = 1'b0; f_id = '0;
    endfunction

    function automatic bit frame_is_ip();
        return f_type == ETYPE_V4 || f_type == ETYPE_V6;
    endfunction

    function automatic int id_offset();
        return f_l4 + (f_form[7] ? 14 : 9);
    endfunction

    function automatic bit conn_find(input bit [63:0] k, output bit [31:0] s);
        s = '0;
        for (int i = 0; i < N_CONN; i++)
            if (conn_on[i] && conn_key[i] == k)
            begin
                s = conn_sock[i];
                return 1'b1;
            end
        return 1'b0;
    endfunction

    function automatic void parse_byte(input bit [7:0] b);
        int p;
        int s;
        p = f_pos;
        if (p == 12) f_type = int'(b) << 8;
        if (p == 13) f_type = f_type | int'(b);
        if (p == 14)
        begin
            if (f_type == ETYPE_V4)
            begin
                f_l4 = 14 + int'(b[3:0]) * 4;
                f_family = 0;
            end
            else
            begin
                f_l4 = 54;
                f_family = 1;
            end
        end
        if (p >= 14 && frame_is_ip())
            if (p == ((f_type == ETYPE_V4) ? 23 : 20) && b == PROTO_UDP) f_udp = 1'b1;
        if (p > 14 && frame_is_ip())
        begin
            if (p == f_l4 + 2) f_port = int'(b) << 8;
            if (p == f_l4 + 3) f_port = f_port | int'(b);
            if (p == f_l4 + 8) f_form = b;
            if (p == f_l4 + 13) f_idlen = b;
            if (p >= f_l4 + 9)
            begin
                s = id_offset();
                if (p >= s && p < s + ID_LEN) f_id |= 64'(b) << (8 * (p - s));
            end
        end
        if (f_pos < 255) f_pos++;
    endfunction

    // verdict for the frame just ended, checks in the block's priority order
    function automatic result_t frame_verdict();
        result_t r;
        bit listed;
        bit [31:0] s;
        r = '0;
        r.verdict = VERDICT_NONE;
        r.reason = RSN_OK;
        listed = 1'b0;
        if (f_pos < 14) r.reason = RSN_SHORT;
        else if (!frame_is_ip()) r.reason = RSN_NOT_IP;
        else if (f_pos < ((f_type == ETYPE_V4) ? 24 : 21)) r.reason = RSN_SHORT;
        else if (!f_udp) r.reason = RSN_NOT_UDP;
        else if (f_pos < f_l4 + 4) r.reason = RSN_SHORT;
        else
        begin
            r.port = f_port[15:0];
            for (int i = 0; i < N_PORT; i++)
                if (port_on[i] && port_num[i] == r.port) listed = 1'b1;
            if (!listed) r.reason = RSN_UNLISTED;
            else if (f_pos < f_l4 + 9) r.reason = RSN_SHORT;
            else if (f_form[7] && f_pos < f_l4 + 14) r.reason = RSN_SHORT;
            else if (f_form[7] && f_idlen < ID_LEN) r.reason = RSN_ID_SHORT;
            else if (f_pos < id_offset() + ID_LEN) r.reason = RSN_SHORT;
            else
            begin
                r.key = f_id;
                if (conn_find(f_id, s)) r.verdict = VERDICT_CONN;
                else if (conn_find({47'd0, r.port, f_family[0]}, s))
                    r.verdict = VERDICT_FALLBACK;
                else r.reason = RSN_NO_ENTRY;
                r.socket = s;
            end
        end
        return r;
    endfunction

    // apply one accepted word to the model
    function automatic void steer_model_word(input bit [1:0] cmd, input bit [7:0] b,
                                             input bit fend, input bit [5:0] slot,
                                             input bit v, input bit [15:0] prt,
                                             input bit [63:0] k, input bit [31:0] s);
        case (cmd)
            CMD_PORT:
                if (slot < N_PORT)
                begin
                    port_on[slot] = v;
                    port_num[slot] = prt;
                end
            CMD_CONN:
            begin
                conn_on[slot] = v;
                conn_key[slot] = k;
                conn_sock[slot] = s;
            end
            CMD_BYTE:
            begin
                parse_byte(b);
                if (fend)
                begin
                    steer_expected.push_back(frame_verdict());
                    clear_frame_state();
                end
            end
            default: ;
        endcase
    endfunction

    // drive one word, wait for it to be taken, then update the model
    task automatic send_word(input bit [1:0] cmd, input bit [7:0] b, input bit fend,
                             input bit [5:0] slot, input bit v, input bit [15:0] prt,
                             input bit [63:0] k, input bit [31:0] s);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        command <= cmd;
        data_byte <= b;
        frame_end <= fend;
        slot_index <= slot;
        entry_valid <= v;
        entry_port <= prt;
        entry_key <= k;
        entry_socket <= s;
        // full is stable at the falling edge; low there means taken next edge
        do @(negedge clk); while (full);
        @(posedge clk);
        steer_model_word(cmd, b, fend, slot, v, prt, k, s);
        words_sent++;
    endtask

    task automatic send_frame(input frame_q_t f);
        for (int i = 0; i < f.size(); i++)
            send_word(CMD_BYTE, f[i], i == f.size() - 1, 6'($urandom), 1'($urandom),
                      16'($urandom), {32'($urandom), 32'($urandom)}, 32'($urandom));
        frames_sent++;
    endtask

    task automatic write_port(input bit [5:0] slot, input bit v, input bit [15:0] prt);
        send_word(CMD_PORT, 8'($urandom), 1'($urandom), slot, v, prt,
                  {32'($urandom), 32'($urandom)}, 32'($urandom));
        if (v && slot < N_PORT) listed_ports.push_back(prt);
    endtask

    task automatic write_conn(input bit [5:0] slot, input bit v, input bit [63:0] k,
                              input bit [31:0] s);
        send_word(CMD_CONN, 8'($urandom), 1'($urandom), slot, v, 16'($urandom), k, s);
        if (v) known_ids.push_back(k);
    endtask

    // lay out a frame; later fields overwrite earlier ones where they overlap
    function automatic frame_q_t make_frame(input bit [15:0] etype, input int ihl,
                                            input bit [7:0] proto, input bit [15:0] prt,
                                            input bit long_hdr, input bit [7:0] idlen,
                                            input bit [63:0] id, input int total);
        bit [7:0] raw[];
        frame_q_t f;
        int l4, s, n0, n;
        l4 = (etype == ETYPE_V4) ? 14 + ihl * 4 : 54;
        s = l4 + (long_hdr ? 14 : 9);
        n0 = s + ID_LEN + $urandom_range(0, 6);
        n = (total > 0) ? total : n0;
        raw = new[(n > n0) ? n : n0];
        foreach (raw[i]) raw[i] = 8'($urandom);
        raw[12] = etype[15:8];
        raw[13] = etype[7:0];
        if (etype == ETYPE_V4) raw[14] = {4'h4, 4'(ihl)};
        raw[(etype == ETYPE_V4) ? 23 : 20] = proto;
        raw[l4 + 2] = prt[15:8];
        raw[l4 + 3] = prt[7:0];
        raw[l4 + 8] = {long_hdr, 7'($urandom)};
        if (long_hdr) raw[l4 + 13] = idlen;
        for (int i = 0; i < ID_LEN; i++) raw[s + i] = id[8 * i +: 8];
        for (int i = 0; i < n; i++) f.push_back(raw[i]);
        return f;
    endfunction

    function automatic bit [15:0] pick_port();
        if (listed_ports.size() > 0 && $urandom_range(0, 99) < 85)
            return listed_ports[$urandom_range(0, listed_ports.size() - 1)];
        return 16'($urandom);
    endfunction

    function automatic bit [63:0] pick_id();
        if (known_ids.size() > 0 && $urandom_range(0, 1))
            return known_ids[$urandom_range(0, known_ids.size() - 1)];
        return {32'($urandom), 32'($urandom)};
    endfunction

    // ------------------------------------------------------------------
    // result checker: pops with random gaps, honors hold-off requests
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        result_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
            gap += hold_len;
            hold_len = 0;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(negedge clk); while (empty);
            // outputs are stable here; the word leaves at the next edge
            if (steer_expected.size() == 0)
            begin
                $error("result word with no frame pending: verdict %0d reason %0d",
                       verdict, reason);
                failures++;
            end
            else
            begin
                want = steer_expected.pop_front();
                if (verdict !== want.verdict)
                begin
                    $error("verdict expected %0d actual %0d", want.verdict, verdict);
                    failures++;
                end
                if (socket_id !== want.socket)
                begin
                    $error("socket_id expected %h actual %h", want.socket, socket_id);
                    failures++;
                end
                if (reason !== want.reason)
                begin
                    $error("reason expected %0d actual %0d", want.reason, reason);
                    failures++;
                end
                if (dest_port !== want.port)
                begin
                    $error("dest_port expected %h actual %h", want.port, dest_port);
                    failures++;
                end
                if (cid_key !== want.key)
                begin
                    $error("cid_key expected %h actual %h", want.key, cid_key);
                    failures++;
                end
                if (want.verdict <= VERDICT_FALLBACK) seen_by_verdict[want.verdict]++;
            end
            @(posedge clk);
            words_popped++;
        end
    end

    // watchdog on cycles where neither side moves a word
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // table writes: extremes, out of range port slot, clears, ignored commands
    task automatic test_table_writes();
        write_port(6'd0, 1'b1, 16'd443);
        write_port(6'd1, 1'b1, 16'hFFFF);
        write_port(6'd2, 1'b1, 16'h0000);
        write_port(6'd3, 1'b1, 16'd4433);
        write_port(6'd15, 1'b1, 16'd8443);
        write_port(6'd40, 1'b1, 16'd9999);       // slot past the table, dropped
        write_port(6'd4, 1'b0, 16'd7777);        // stored but inactive
        write_conn(6'd0, 1'b1, 64'h0, 32'hFFFF_FFFF);
        write_conn(6'd1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        write_conn(6'd2, 1'b1, 64'h0102_0304_0506_0708, 32'h1111_2222);
        write_conn(6'd63, 1'b1, 64'h0102_0304_0506_0708, 32'h3333_4444); // lower wins
        write_conn(6'd10, 1'b1, {47'd0, 16'd4433, 1'b0}, 32'hFA11_0004); // v4 fallback
        write_conn(6'd11, 1'b1, {47'd0, 16'd8443, 1'b1}, 32'hFA11_0006); // v6 fallback
        write_conn(6'd12, 1'b0, 64'hDEAD_BEEF_0000_0001, 32'h5);         // cleared
        send_word(CMD_NONE, 8'hFF, 1'b1, 6'h3F, 1'b1, 16'hFFFF, '1, '1);
        for (int i = 20; i < 50; i++)
            write_conn(6'(i), 1'b1, {32'($urandom), 32'($urandom)}, 32'($urandom));
    endtask

    // one frame for each parse outcome and corner case
    task automatic test_directed_frames();
        send_frame(make_frame(ETYPE_V4, 5, PROTO_UDP, 16'd443, 0, 0, 64'h0, 1));
        send_frame(make_frame(ETYPE_V4, 5, PROTO_UDP, 16'd443, 0, 0, 64'h0, 13));
        send_frame(make_frame(16'h86DC, 5, PROTO_UDP, 16'd443, 0, 0, 64'h0, 0));
        send_frame(make_frame(ETYPE_V4, 5, 8'd6, 16'd443, 0, 0, 64'h0, 0));
        send_frame(make_frame(ETYPE_V4, 5, PROTO_UDP, 16'd1234, 0, 0, 64'h0, 0));
        send_frame(make_frame(ETYPE_V4, 5, PROTO_UDP, 16'd443, 0, 0, '1, 0));
        send_frame(make_frame(ETYPE_V4, 15, PROTO_UDP, 16'hFFFF, 1, 8'd8,
                              64'h0102_0304_0506_0708, 0));
        send_frame(make_frame(ETYPE_V6, 0, PROTO_UDP, 16'h0000, 1, 8'd255, 64'h0, 0));
        send_frame(make_frame(ETYPE_V4, 5, PROTO_UDP, 16'd443, 1, 8'd7, 64'h0, 0));
        send_frame(make_frame(ETYPE_V4, 5, PROTO_UDP, 16'd443, 1, 8'd0, 64'h0, 0));
        send_frame(make_frame(ETYPE_V4, 5, PROTO_UDP, 16'd4433, 0, 0, 64'h77, 0));
        send_frame(make_frame(ETYPE_V6, 0, PROTO_UDP, 16'd8443, 1, 8'd20, 64'h78, 0));
        send_frame(make_frame(ETYPE_V6, 0, PROTO_UDP, 16'd443, 0, 0, 64'h79, 0));
        // ihl below five: udp header overlaps the ip header
        send_frame(make_frame(ETYPE_V4, 0, PROTO_UDP, 16'd443, 0, 0, 64'h0, 0));
        send_frame(make_frame(ETYPE_V4, 2, PROTO_UDP, 16'd443, 1, 8'd9, '1, 0));
        // cut inside the ip header, the port, the udp header and before the first payload byte
        send_frame(make_frame(ETYPE_V4, 5, PROTO_UDP, 16'd443, 1, 8'd8, '1, 23));
        send_frame(make_frame(ETYPE_V6, 0, PROTO_UDP, 16'd443, 0, 0, '1, 57));
        send_frame(make_frame(ETYPE_V4, 5, PROTO_UDP, 16'd443, 1, 8'd8, '1, 42));
        send_frame(make_frame(ETYPE_V4, 5, PROTO_UDP, 16'd443, 0, 0, '1, 40));
        // longer than the byte counter range
        send_frame(make_frame(ETYPE_V4, 5, PROTO_UDP, 16'd443, 0, 0, '1, 260));
    endtask

    // receiver holds off while the sender keeps pushing short frames
    task automatic test_backpressure();
        hold_len = 600;
        no_gaps = 1'b1;
        for (int i = 0; i < 8; i++)
            send_frame(make_frame(ETYPE_V4, 5, PROTO_UDP, pick_port(), 0, 0,
                                  pick_id(), 0));
        no_gaps = 1'b0;
    endtask

    // mostly well formed frames with random content, some noise and updates
    task automatic test_random_traffic();
        int start_words, pick, ihl, cut;
        bit [15:0] et;
        frame_q_t f;
        start_words = words_sent;
        while (words_sent - start_words < 200)
        begin
            pick = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (pick < 4)
                send_word(CMD_NONE, 8'($urandom), 1'($urandom), 6'($urandom),
                          1'($urandom), 16'($urandom), {32'($urandom), 32'($urandom)},
                          32'($urandom));
            else if (pick < 9)
                write_port(6'($urandom), ($urandom_range(0, 3) != 0), 16'($urandom));
            else if (pick < 16)
            begin
                if ($urandom_range(0, 1))
                    write_conn(6'($urandom), ($urandom_range(0, 4) != 0),
                               {32'($urandom), 32'($urandom)}, 32'($urandom));
                else
                    write_conn(6'($urandom), 1'b1,
                               {47'd0, pick_port(), 1'($urandom)}, 32'($urandom));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                et = pick < 78 ? ETYPE_V4 : pick < 95 ? ETYPE_V6 : 16'($urandom);
                ihl = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4)
                                                : $urandom_range(5, 15);
                cut = $urandom_range(0, 3) == 0 ? $urandom_range(1, 80) : 0;
                f = make_frame(et, ihl,
                               $urandom_range(0, 9) == 0 ? 8'($urandom) : PROTO_UDP,
                               pick_port(), 1'($urandom),
                               $urandom_range(0, 6) == 0 ? 8'($urandom_range(0, 7))
                                                         : 8'($urandom),
                               pick_id(), cut);
                send_frame(f);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        clear_frame_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_writes();
        test_directed_frames();
        test_backpressure();
        test_random_traffic();

        push <= 1'b0;
        wait (steer_expected.size() == 0);
        repeat (120) @(posedge clk);

        $display("covered %0d words, %0d frames, %0d results checked", words_sent,
                 frames_sent, words_popped);
        $display("verdicts: %0d not steered, %0d id match, %0d fallback",
                 seen_by_verdict[0], seen_by_verdict[1], seen_by_verdict[2]);
        if (failures == 0 && steer_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
